// ===== rtl/core/nuas_pkg.sv =====
// Shared types, sizes and codes for the next-unused-above selector.
`default_nettype none

package nuas_pkg;

    localparam int NUM_ENTRIES = 1024;
    localparam int GROUP_SIZE  = 32;
    localparam int NUM_GROUPS  = NUM_ENTRIES / GROUP_SIZE;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_NONE = 2'd1;
    localparam status_t STATUS_FULL = 2'd2;

    typedef struct packed {
        logic   insert;
        logic   capture;
        value_t key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/next_unused_above_selector_core.sv =====
// Top level of the next-unused-above selector: cell chain, group select and sequencer.
//
//  Channel  Handshake            Word fields
//  -------  -------------------  ------------------------------
//  in       in_valid / in_stall   func, key
//  out      out_valid / out_stall picked_value, status
//
// A load goes from acceptance to result by compare and shift in the chain, then output.
// A query steps through compare, group select, group merge, mark update and output.
// One word is in work at a time, so the next word is taken only once the last result is output;
// the sequencer sets this pace.
// Reset clears all valid bits and used marks at once; stored values need no reset.
// A result waiting under out_stall holds; the next word is taken and waits at its last step.
`default_nettype none

module next_unused_above_selector_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  nuas_pkg::value_t  key,
    output logic              out_valid,
    input  logic              out_stall,
    output nuas_pkg::value_t  picked_value,
    output nuas_pkg::status_t status
);
    import nuas_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL1,
        ST_SEL2,
        ST_MARK,
        ST_DONE
    } state_t;

    state_t  state_reg;
    logic    func_reg;
    value_t  key_reg;
    value_t  res_value_reg;
    status_t res_status_reg;
    logic    found_reg;
    logic [NUM_GROUPS-1:0] grp_sel_reg;
    logic    out_valid_reg;
    value_t  out_value_reg;
    status_t out_status_reg;

    cell_ctrl_t ctrl;
    logic [NUM_ENTRIES-1:0] gt_vec;
    logic [NUM_ENTRIES-1:0] used_vec;
    logic [NUM_ENTRIES-1:0] valid_vec;
    logic [NUM_ENTRIES-1:0] match_vec;
    logic [NUM_ENTRIES-1:0] set_used_vec;
    value_t cell_value [NUM_ENTRIES];

    logic [NUM_GROUPS-1:0][GROUP_SIZE-1:0] grp_onehot;
    logic [NUM_GROUPS-1:0] grp_any;
    value_t grp_value [NUM_GROUPS];

    logic [NUM_GROUPS-1:0] grp_sel_next;
    value_t pick_next;
    logic   full;
    logic   accept;

    assign full   = valid_vec[NUM_ENTRIES-1];
    assign accept = in_valid && (state_reg == ST_IDLE);

    assign ctrl.insert  = (state_reg == ST_CMP) && (func_reg == FUNC_LOAD) && !full;
    assign ctrl.capture = (state_reg == ST_CMP) && (func_reg == FUNC_QUERY);
    assign ctrl.key     = key_reg;

    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        logic   p_gt;
        value_t p_value;
        logic   p_used;
        logic   p_valid;

        if (i == 0)
        begin : g_head
            assign p_gt    = 1'b0;
            assign p_value = '0;
            assign p_used  = 1'b0;
            assign p_valid = 1'b0;
        end
        else
        begin : g_link
            assign p_gt    = gt_vec[i-1];
            assign p_value = cell_value[i-1];
            assign p_used  = used_vec[i-1];
            assign p_valid = valid_vec[i-1];
        end

        assign set_used_vec[i] = (state_reg == ST_MARK) && grp_sel_reg[i / GROUP_SIZE]
                                 && grp_onehot[i / GROUP_SIZE][i % GROUP_SIZE];

        nuas_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .set_used   (set_used_vec[i]),
            .prev_gt    (p_gt),
            .prev_value (p_value),
            .prev_used  (p_used),
            .prev_valid (p_valid),
            .gt         (gt_vec[i]),
            .value      (cell_value[i]),
            .used       (used_vec[i]),
            .valid      (valid_vec[i]),
            .match      (match_vec[i])
        );
    end

    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        value_t grp_in [GROUP_SIZE];

        for (genvar j = 0; j < GROUP_SIZE; j++)
        begin : g_tap
            assign grp_in[j] = cell_value[g * GROUP_SIZE + j];
        end

        nuas_group u_group (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (state_reg == ST_SEL1),
            .match  (match_vec[g * GROUP_SIZE +: GROUP_SIZE]),
            .values (grp_in),
            .onehot (grp_onehot[g]),
            .any    (grp_any[g]),
            .value  (grp_value[g])
        );
    end

    always_comb
    begin
        grp_sel_next = grp_any & (~grp_any + {{(NUM_GROUPS-1){1'b0}}, 1'b1});
        pick_next    = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            pick_next = pick_next | (grp_value[g] & {VALUE_W{grp_sel_next[g]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            func_reg       <= FUNC_LOAD;
            key_reg        <= '0;
            res_value_reg  <= '0;
            res_status_reg <= STATUS_OK;
            found_reg      <= 1'b0;
            grp_sel_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= func;
                        key_reg   <= key;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (func_reg == FUNC_LOAD)
                    begin
                        res_value_reg  <= '0;
                        res_status_reg <= full ? STATUS_FULL : STATUS_OK;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SEL1;
                    end
                end
                ST_SEL1:
                begin
                    state_reg <= ST_SEL2;
                end
                ST_SEL2:
                begin
                    grp_sel_reg    <= grp_sel_next;
                    found_reg      <= |grp_any;
                    res_value_reg  <= pick_next;
                    res_status_reg <= (|grp_any) ? STATUS_OK : STATUS_NONE;
                    state_reg      <= ST_MARK;
                end
                ST_MARK:
                begin
                    grp_sel_reg <= '0;
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign picked_value = out_value_reg;
    assign status       = out_status_reg;

`ifndef SYNTH
    // Stored entries always fill the chain from the head with no gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{NUM_ENTRIES{1'b0}}, 1'b1}))
        else $error("valid cells are not a contiguous prefix");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grp_sel_reg))
        else $error("more than one group selected");

    // A successful query marks exactly one more entry as used.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK && found_reg)
        |=> $countones(used_vec) == $past($countones(used_vec)) + 1)
        else $error("query did not mark exactly one entry");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nuas_cell.sv =====
// One storage cell of the sorted chain: value, used mark, valid bit and match flag.
`default_nettype none

module nuas_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  nuas_pkg::cell_ctrl_t ctrl,
    input  logic                set_used,
    input  logic                prev_gt,
    input  nuas_pkg::value_t    prev_value,
    input  logic                prev_used,
    input  logic                prev_valid,
    output logic                gt,
    output nuas_pkg::value_t    value,
    output logic                used,
    output logic                valid,
    output logic                match
);
    import nuas_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   used_reg;
    logic   used_next;
    logic   valid_reg;
    logic   valid_next;
    logic   match_reg;
    logic   match_next;

    // An empty cell counts as holding a value above every key.
    assign gt = !valid_reg || (value_reg > ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        used_next  = used_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.insert && gt)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
                used_next  = prev_used;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = ctrl.key;
                used_next  = 1'b0;
                valid_next = 1'b1;
            end
        end
        else if (set_used)
        begin
            used_next = 1'b1;
        end
        if (ctrl.capture)
        begin
            match_next = valid_reg && gt && !used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign used  = used_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nuas_group.sv =====
// First-match select and value pick over one group of cells.
`default_nettype none

module nuas_group (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic [nuas_pkg::GROUP_SIZE-1:0]       match,
    input  nuas_pkg::value_t                      values [nuas_pkg::GROUP_SIZE],
    output logic [nuas_pkg::GROUP_SIZE-1:0]       onehot,
    output logic                                  any,
    output nuas_pkg::value_t                      value
);
    import nuas_pkg::*;

    logic [GROUP_SIZE-1:0] onehot_reg;
    logic [GROUP_SIZE-1:0] onehot_next;
    logic                  any_reg;
    value_t                value_reg;
    value_t                value_next;

    always_comb
    begin
        onehot_next = match & (~match + {{(GROUP_SIZE-1){1'b0}}, 1'b1});
        value_next  = '0;
        for (int j = 0; j < GROUP_SIZE; j++)
        begin
            value_next = value_next | (values[j] & {VALUE_W{onehot_next[j]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            onehot_reg <= '0;
            any_reg    <= 1'b0;
        end
        else if (load)
        begin
            onehot_reg <= onehot_next;
            any_reg    <= |match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign onehot = onehot_reg;
    assign any    = any_reg;
    assign value  = value_reg;

endmodule

`default_nettype wire
